// ----- design/dqr_pkg.sv -----
`timescale 1ns / 1ps

package dqr_pkg;

  // Fixed payload widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned COUNT_W = 6;

  // Default storage depth
  localparam int unsigned DEPTH_DEF = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;       // request accepted: capture index
    logic push_back;
    logic push_front;
    logic pop_back;    // read back entry, shrink
    logic pop_front;   // read front entry, advance front
    logic shift_rd;    // read entry k+1
    logic shift_wr;    // write read word to entry k, step k
    logic rm_done;     // removal finished, shrink
    logic load_res;    // capture result register
    logic res_ok;
    logic res_mem;     // result data from memory read register
  } dqr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic in_range;    // request index below count
    logic shift_more;  // k+1 below count
  } dqr_sts_t;

endpackage

// ----- design/dqr_if.sv -----
`timescale 1ns / 1ps

// Request channel
interface dqr_req_if
  import dqr_pkg::*;
();
  logic   valid;
  logic   ready;
  op_t    operation;
  value_t value;
  index_t index;

  modport source (output valid, output operation, output value, output index,
                  input ready);
  modport sink   (input valid, input operation, input value, input index,
                  output ready);
endinterface

// Result channel
interface dqr_res_if
  import dqr_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   ok;
  value_t data_out;
  count_t count;
  logic   empty_res;

  modport source (output valid, output ok, output data_out, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input ok, input data_out, input count,
                  input empty_res, output ready);
endinterface

// ----- design/dqr_ctrl.sv -----
`timescale 1ns / 1ps

module dqr_ctrl
  import dqr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  op_t      req_op_i,
  output logic     req_ready_o,
  input  logic     res_ready_i,
  output logic     res_valid_o,
  input  dqr_sts_t sts_i,
  output dqr_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_POP      = 4'b0010,
    S_SHIFT_RD = 4'b0100,
    S_SHIFT_WR = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   res_vld_q, res_vld_d;
  logic   res_free;

  // Result register may be loaded when empty or being drained
  assign res_free    = ~res_vld_q | res_ready_i;
  assign req_ready_o = (state_q == S_IDLE) & res_free;
  assign res_valid_o = res_vld_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.latch = 1'b1;
          case (req_op_i)
            OP_PUSH_BACK: begin
              cmd_o.push_back = ~sts_i.full;
              cmd_o.load_res  = 1'b1;
              cmd_o.res_ok    = ~sts_i.full;
            end
            OP_PUSH_FRONT: begin
              cmd_o.push_front = ~sts_i.full;
              cmd_o.load_res   = 1'b1;
              cmd_o.res_ok     = ~sts_i.full;
            end
            OP_POP_BACK: begin
              if (sts_i.empty) begin
                cmd_o.load_res = 1'b1;
              end else begin
                cmd_o.pop_back = 1'b1;
                state_d        = S_POP;
              end
            end
            OP_POP_FRONT: begin
              if (sts_i.empty) begin
                cmd_o.load_res = 1'b1;
              end else begin
                cmd_o.pop_front = 1'b1;
                state_d         = S_POP;
              end
            end
            OP_REMOVE: begin
              if (sts_i.in_range) begin
                state_d = S_SHIFT_RD;
              end else begin
                cmd_o.load_res = 1'b1;
              end
            end
            default: begin
              cmd_o.load_res = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (res_free) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_ok   = 1'b1;
          cmd_o.res_mem  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end else if (res_free) begin
          cmd_o.rm_done  = 1'b1;
          cmd_o.load_res = 1'b1;
          cmd_o.res_ok   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    res_vld_d = res_vld_q;
    if (cmd_o.load_res) begin
      res_vld_d = 1'b1;
    end else if (res_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

endmodule

// ----- design/dqr_dpath.sv -----
`timescale 1ns / 1ps

module dqr_dpath
  import dqr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  value_t   req_value_i,
  input  index_t   req_index_i,
  input  dqr_cmd_t cmd_i,
  output dqr_sts_t sts_o,
  output logic     res_ok_o,
  output value_t   res_data_o,
  output count_t   res_count_o,
  output logic     res_empty_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int unsigned CXW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  // Ring storage and read register
  value_t        mem [DEPTH];
  value_t        rd_q;

  logic [PW-1:0] front_q, front_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [PW-1:0] k_q, k_d;

  logic          we, re;
  logic [PW-1:0] waddr, raddr;
  value_t        wdata;

  logic [PW-1:0] front_dec;
  logic [PW:0]   fill_p, k_inc;
  logic [CMPW-1:0] idx_ext;
  logic [CXW-1:0]  fill_ext;

  logic          res_ok_q;
  value_t        res_data_q;
  count_t        res_count_q;
  logic          res_empty_q;

  // Ring slot k places behind the front
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] front,
                                            input logic [PW:0] k);
    logic [PW:0] s;
    s = {1'b0, front} + k;
    if (s >= DEPTH_P) begin
      s = s - DEPTH_P;
    end
    return s[PW-1:0];
  endfunction

  assign fill_p    = (PW + 1)'(fill_q);
  assign k_inc     = {1'b0, k_q} + (PW + 1)'(1);
  assign idx_ext   = CMPW'(req_index_i);
  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - PW'(1);

  // Status
  assign sts_o.full       = (fill_q == DEPTH_C);
  assign sts_o.empty      = (fill_q == '0);
  assign sts_o.in_range   = (idx_ext < CMPW'(fill_q));
  assign sts_o.shift_more = (k_inc < fill_p);

  // Memory access and pointer updates
  always_comb begin
    we      = 1'b0;
    re      = 1'b0;
    waddr   = slot_of(front_q, fill_p);
    raddr   = front_q;
    wdata   = req_value_i;
    front_d = front_q;
    fill_d  = fill_q;
    k_d     = k_q;
    if (cmd_i.latch) begin
      k_d = idx_ext[PW-1:0];
    end
    if (cmd_i.push_back) begin
      we     = 1'b1;
      fill_d = fill_q + CW'(1);
    end
    if (cmd_i.push_front) begin
      we      = 1'b1;
      waddr   = front_dec;
      front_d = front_dec;
      fill_d  = fill_q + CW'(1);
    end
    if (cmd_i.pop_back) begin
      re     = 1'b1;
      raddr  = slot_of(front_q, fill_p - (PW + 1)'(1));
      fill_d = fill_q - CW'(1);
    end
    if (cmd_i.pop_front) begin
      re      = 1'b1;
      raddr   = front_q;
      front_d = slot_of(front_q, (PW + 1)'(1));
      fill_d  = fill_q - CW'(1);
    end
    if (cmd_i.shift_rd) begin
      re    = 1'b1;
      raddr = slot_of(front_q, k_inc);
    end
    if (cmd_i.shift_wr) begin
      we    = 1'b1;
      waddr = slot_of(front_q, {1'b0, k_q});
      wdata = rd_q;
      k_d   = k_inc[PW-1:0];
    end
    if (cmd_i.rm_done) begin
      fill_d = fill_q - CW'(1);
    end
  end

  assign fill_ext = CXW'(fill_d);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      fill_q  <= '0;
    end else begin
      front_q <= front_d;
      fill_q  <= fill_d;
    end
  end

  // Removal cursor and result register
  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (cmd_i.load_res) begin
      res_ok_q    <= cmd_i.res_ok;
      res_data_q  <= cmd_i.res_mem ? rd_q : '0;
      res_count_q <= fill_ext[COUNT_W-1:0];
      res_empty_q <= (fill_d == '0);
    end
  end

  assign res_ok_o    = res_ok_q;
  assign res_data_o  = res_data_q;
  assign res_count_o = res_count_q;
  assign res_empty_o = res_empty_q;

endmodule

// ----- design/deque_with_indexed_remove.sv -----
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words held in a DEPTH-entry
// single-port ring memory. Each request transaction yields one result
// transaction with ok, the popped word, the count and an empty flag. A push
// or a rejected request completes in the cycle it is accepted. A pop waits
// in S_POP for the registered memory read and a free output register. A
// removal at position i runs through the accepting cycle, one read and one
// write on the memory port for each entry that moves toward the front, and
// a closing step that loads the result once the output register is free.
// A new request is taken only while the block is idle and the output
// register is empty or being read in that cycle, so a result left unread
// holds off the next request.
module deque_with_indexed_remove
  import dqr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dqr_req_if.sink   req_i,
  dqr_res_if.source res_o
);

  dqr_cmd_t cmd;
  dqr_sts_t sts;

  dqr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dqr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_value_i (req_i.value),
    .req_index_i (req_i.index),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_ok_o    (res_o.ok),
    .res_data_o  (res_o.data_out),
    .res_count_o (res_o.count),
    .res_empty_o (res_o.empty_res)
  );

endmodule
